FILE: src/whp_pkg.sv
package whp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_FMT_SEEK,
        PH_FMT_BODY,
        PH_DATA_SEEK,
        PH_DATA_SIZE,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NOT_RIFF = 3'd0,
        ERR_NOT_WAVE = 3'd1,
        ERR_NO_FMT   = 3'd2,
        ERR_NOT_PCM  = 3'd3,
        ERR_NO_DATA  = 3'd4
    } t_err;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FORMAT_PCM = 16'd1;
    localparam logic [32:0] OFF_MAX    = {33{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
        logic [7:0]  payload_byte;
        logic        last;
    } t_out;

    // The window holds the newest byte in the low lane, so little-endian
    // values come out with the lanes reversed.
    function automatic logic [31:0] le32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [15:0] le16(input logic [31:0] w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

FILE: src/wav_header_parser.sv
// Throughput: one byte per cycle while o_in_ready is high; the whole parse step
// for a byte sits in one combinational pass between the state registers and the
// result register. A one-entry skid stage keeps input flowing while a result
// waits to be taken.
// Reset (synchronous, active low) clears the parser to idle: bytes are ignored
// until a beat with file_start set.
module wav_header_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  whp_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output whp_pkg::t_out  o_out_data
);
    import whp_pkg::*;

    localparam logic [4:0] REL_START   = 5'd4;
    localparam logic [4:0] REL_TAG     = 5'd9;
    localparam logic [4:0] REL_CHAN    = 5'd11;
    localparam logic [4:0] REL_RATE    = 5'd15;
    localparam logic [4:0] REL_BRATE   = 5'd19;
    localparam logic [4:0] REL_ALIGN   = 5'd21;
    localparam logic [4:0] REL_BITS    = 5'd23;
    localparam logic [4:0] REL_DSIZE   = 5'd7;
    localparam logic [1:0] FILL_FULL   = 2'd3;
    localparam logic [32:0] OFF_TAG1   = 33'd3;
    localparam logic [32:0] OFF_SIZE   = 33'd7;
    localparam logic [32:0] OFF_TAG2   = 33'd11;
    localparam logic [32:0] LIMIT_BIAS = 33'd11;

    t_phase      r_phase, n_phase;
    logic [32:0] r_off, n_off;
    logic [31:0] r_window, n_window;
    logic [1:0]  r_fill, n_fill;
    logic [4:0]  r_rel, n_rel;
    logic [32:0] r_limit, n_limit;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_brate, n_brate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_left, n_left;

    logic        r_out_valid;
    t_out        r_out;
    logic        r_skid_valid;
    t_out        r_skid;

    logic        accept;
    logic        res_valid;
    t_out        res;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        t_phase      ph;
        logic [32:0] off;
        logic [31:0] w;
        logic [31:0] dsize;
        logic [31:0] left_dec;

        n_phase  = r_phase;
        n_off    = r_off;
        n_window = r_window;
        n_fill   = r_fill;
        n_rel    = r_rel;
        n_limit  = r_limit;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_brate  = r_brate;
        n_align  = r_align;
        n_bits   = r_bits;
        n_left   = r_left;
        res       = '0;
        res_valid = 1'b0;

        ph       = r_phase;
        off      = r_off;
        w        = {r_window[23:0], i_in_data.data_byte};
        dsize    = le32(w);
        left_dec = r_left - 32'd1;

        if (accept) begin
            if (i_in_data.file_start) begin
                ph       = PH_HEAD;
                off      = '0;
                w        = {24'd0, i_in_data.data_byte};
                dsize    = le32(w);
                n_phase  = PH_HEAD;
                n_limit  = '0;
                n_left   = '0;
            end

            if (ph != PH_IDLE && ph != PH_DONE) begin
                n_off    = (off != OFF_MAX) ? off + 33'd1 : off;
                n_window = w;

                unique case (ph)
                    PH_HEAD: begin
                        if (off == OFF_TAG1 && w != TAG_RIFF) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NOT_RIFF;
                            res.last       = 1'b1;
                            n_phase        = PH_DONE;
                        end else if (off == OFF_SIZE) begin
                            // Window starts at or past riff_size + 8 fail; judged at
                            // the window's fourth byte, so compare the offset against +11.
                            n_limit = {1'b0, le32(w)} + LIMIT_BIAS;
                        end else if (off == OFF_TAG2) begin
                            if (w != TAG_WAVE) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_NOT_WAVE;
                                res.last       = 1'b1;
                                n_phase        = PH_DONE;
                            end else begin
                                n_phase = PH_FMT_SEEK;
                                n_fill  = '0;
                            end
                        end
                    end
                    PH_FMT_SEEK, PH_DATA_SEEK: begin
                        // A window is complete once three bytes of the search have
                        // already arrived ahead of the current one.
                        if (r_fill != FILL_FULL) begin
                            n_fill = r_fill + 2'd1;
                        end else if (off >= r_limit) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = (ph == PH_FMT_SEEK) ? ERR_NO_FMT : ERR_NO_DATA;
                            res.last       = 1'b1;
                            n_phase        = PH_DONE;
                        end else if (w == ((ph == PH_FMT_SEEK) ? TAG_FMT : TAG_DATA)) begin
                            n_phase = (ph == PH_FMT_SEEK) ? PH_FMT_BODY : PH_DATA_SIZE;
                            n_rel   = REL_START;
                        end
                    end
                    PH_FMT_BODY: begin
                        n_rel = r_rel + 5'd1;
                        case (r_rel)
                            REL_TAG: begin
                                if (le16(w) != FORMAT_PCM) begin
                                    res_valid      = 1'b1;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_NOT_PCM;
                                    res.last       = 1'b1;
                                    n_phase        = PH_DONE;
                                end
                            end
                            REL_CHAN:  n_chan  = le16(w);
                            REL_RATE:  n_rate  = le32(w);
                            REL_BRATE: n_brate = le32(w);
                            REL_ALIGN: n_align = le16(w);
                            REL_BITS: begin
                                n_bits  = le16(w);
                                n_phase = PH_DATA_SEEK;
                                n_fill  = '0;
                            end
                            default: ;
                        endcase
                    end
                    PH_DATA_SIZE: begin
                        n_rel = r_rel + 5'd1;
                        if (r_rel == REL_DSIZE) begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_HEADER;
                            res.channels      = r_chan;
                            res.sample_rate   = r_rate;
                            res.avg_byte_rate = r_brate;
                            res.block_align   = r_align;
                            res.sample_bits   = r_bits;
                            res.data_size     = dsize;
                            res.last          = (dsize == '0);
                            n_left            = dsize;
                            n_phase           = (dsize == '0) ? PH_DONE : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = i_in_data.data_byte;
                        res.last         = (left_dec == '0);
                        n_left           = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_off    <= '0;
            r_window <= '0;
            r_fill   <= '0;
            r_rel    <= '0;
            r_limit  <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_window <= n_window;
            r_fill   <= n_fill;
            r_rel    <= n_rel;
            r_limit  <= n_limit;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan  <= n_chan;
        r_rate  <= n_rate;
        r_brate <= n_brate;
        r_align <= n_align;
        r_bits  <= n_bits;
    end

    // Result register with a one-entry skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while the result register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid stage filled without a stalled result");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.kind == KIND_ERROR) |-> (res.last && n_phase == PH_DONE))
        else $error("error result not final");

    a_quiet_when_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_data.file_start && (r_phase == PH_IDLE || r_phase == PH_DONE))
        |-> !res_valid)
        else $error("result produced while parser is parked");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(accept && i_in_data.file_start)) |=> r_phase == PH_DONE)
        else $error("parser left the finished state without a file start");

endmodule

FILE: tb/wav_header_parser_test.sv
module wav_header_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import whp_pkg::*;

    localparam int PHASE_BEATS  = 350;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTED  = 100;
    localparam int MAX_PAYLOAD  = 40;
    localparam int RUN_LIMIT_NS = 4_000_000;

    localparam logic [31:0] NOT_RIFF_TAG = 32'h5249_4658;
    localparam logic [31:0] NOT_WAVE_TAG = 32'h5741_5646;

    typedef enum int {
        FL_CLEAN,
        FL_EMPTY,
        FL_NOT_PCM,
        FL_NO_FMT,
        FL_NO_DATA,
        FL_HUGE,
        FL_CORRUPT,
        FL_CUT,
        FL_TRAIL,
        FL_NOISE,
        FL_COUNT
    } t_flavor;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    wav_header_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Parser model state.
    t_phase      parse_phase   = PH_IDLE;
    logic [32:0] next_offset   = '0;
    logic [32:0] floor_pos     = '0;
    logic [31:0] tag_window    = '0;
    logic [31:0] riff_len      = '0;
    logic [31:0] rate_val      = '0;
    logic [31:0] byte_rate_val = '0;
    logic [31:0] payload_left  = '0;
    logic [15:0] format_val    = '0;
    logic [15:0] chan_val      = '0;
    logic [15:0] align_val     = '0;
    logic [15:0] bits_val      = '0;

    t_out       parse_results_due[$];
    t_in        pending_bytes[$];
    logic [7:0] file_image[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit stall_armed    = 1'b0;
    bit stall_done     = 1'b0;
    int stall_left     = 0;
    int beats_queued   = 0;
    int beats_accepted = 0;
    int files_queued   = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int kind_seen[3]   = '{0, 0, 0};

    task automatic parse_wav_byte(input t_in beat);
        logic [32:0] here;
        logic [32:0] limit_pos;
        logic [32:0] win_start;
        logic [32:0] rel;
        t_out        res;
        logic        hit;
        logic        err_hit;
        t_err        err_code;
        hit      = 1'b0;
        err_hit  = 1'b0;
        err_code = ERR_NOT_RIFF;
        res      = '0;
        if (beat.file_start) begin
            next_offset   = '0;
            floor_pos     = '0;
            tag_window    = '0;
            riff_len      = '0;
            rate_val      = '0;
            byte_rate_val = '0;
            payload_left  = '0;
            format_val    = '0;
            chan_val      = '0;
            align_val     = '0;
            bits_val      = '0;
            parse_phase   = PH_HEAD;
        end
        if (parse_phase != PH_IDLE && parse_phase != PH_DONE) begin
            here = next_offset;
            if (next_offset != OFF_MAX) next_offset = next_offset + 33'd1;
            tag_window = {tag_window[23:0], beat.data_byte};
            limit_pos  = {1'b0, riff_len} + 33'd8;
            case (parse_phase)
                PH_HEAD: begin
                    if (here == 33'd3 && tag_window != TAG_RIFF) begin
                        err_hit  = 1'b1;
                        err_code = ERR_NOT_RIFF;
                    end else if (here == 33'd7) begin
                        riff_len = {<<8{tag_window}};
                    end else if (here == 33'd11) begin
                        if (tag_window != TAG_WAVE) begin
                            err_hit  = 1'b1;
                            err_code = ERR_NOT_WAVE;
                        end else begin
                            parse_phase = PH_FMT_SEEK;
                            floor_pos   = 33'd12;
                        end
                    end
                end
                PH_FMT_SEEK, PH_DATA_SEEK: begin
                    // A window is judged once its fourth byte has arrived.
                    if (here >= floor_pos + 33'd3) begin
                        win_start = here - 33'd3;
                        if (win_start >= limit_pos) begin
                            err_hit  = 1'b1;
                            err_code = (parse_phase == PH_FMT_SEEK) ? ERR_NO_FMT : ERR_NO_DATA;
                        end else if (parse_phase == PH_FMT_SEEK && tag_window == TAG_FMT) begin
                            floor_pos   = win_start;
                            parse_phase = PH_FMT_BODY;
                        end else if (parse_phase == PH_DATA_SEEK && tag_window == TAG_DATA) begin
                            floor_pos   = win_start;
                            parse_phase = PH_DATA_SIZE;
                        end
                    end
                end
                PH_FMT_BODY: begin
                    rel = here - floor_pos;
                    case (rel)
                        33'd9: begin
                            format_val = {<<8{tag_window[15:0]}};
                            if (format_val != FORMAT_PCM) begin
                                err_hit  = 1'b1;
                                err_code = ERR_NOT_PCM;
                            end
                        end
                        33'd11: chan_val      = {<<8{tag_window[15:0]}};
                        33'd15: rate_val      = {<<8{tag_window}};
                        33'd19: byte_rate_val = {<<8{tag_window}};
                        33'd21: align_val     = {<<8{tag_window[15:0]}};
                        33'd23: begin
                            bits_val    = {<<8{tag_window[15:0]}};
                            floor_pos   = floor_pos + 33'd24;
                            parse_phase = PH_DATA_SEEK;
                        end
                        default: ;
                    endcase
                end
                PH_DATA_SIZE: begin
                    if (here - floor_pos == 33'd7) begin
                        payload_left      = {<<8{tag_window}};
                        res.kind          = KIND_HEADER;
                        res.channels      = chan_val;
                        res.sample_rate   = rate_val;
                        res.avg_byte_rate = byte_rate_val;
                        res.block_align   = align_val;
                        res.sample_bits   = bits_val;
                        res.data_size     = payload_left;
                        res.last          = (payload_left == 32'd0);
                        parse_phase       = (payload_left == 32'd0) ? PH_DONE : PH_PAYLOAD;
                        hit               = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    payload_left     = payload_left - 32'd1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = beat.data_byte;
                    res.last         = (payload_left == 32'd0);
                    if (payload_left == 32'd0) parse_phase = PH_DONE;
                    hit = 1'b1;
                end
                default: parse_phase = PH_DONE;
            endcase
            if (err_hit) begin
                res.kind       = KIND_ERROR;
                res.error_code = err_code;
                res.last       = 1'b1;
                parse_phase    = PH_DONE;
            end
            if (hit || err_hit) parse_results_due.insert(parse_results_due.size(), res);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic logic [31:0] pick_field();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_le(input logic [31:0] value, input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++) file_image.insert(file_image.size(), value[8*i +: 8]);
    endtask

    // Tags go out first character first, so the high byte leads.
    task automatic add_tag(input logic [31:0] tag);
        int i;
        for (i = 3; i >= 0; i--) file_image.insert(file_image.size(), tag[8*i +: 8]);
    endtask

    task automatic add_junk(input int nbytes);
        repeat (nbytes) file_image.insert(file_image.size(), 8'($urandom));
    endtask

    task automatic queue_image(input logic starts_file);
        t_in beat;
        int  i;
        for (i = 0; i < file_image.size(); i++) begin
            beat.data_byte  = file_image[i];
            beat.file_start = starts_file && (i == 0);
            pending_bytes.insert(pending_bytes.size(), beat);
            beats_queued++;
        end
        if (starts_file) files_queued++;
    endtask

    task automatic build_wav_file(input t_flavor flavor);
        logic [31:0] riff_field;
        logic [31:0] data_len;
        logic [15:0] fmt_code;
        int          pre_fmt;
        int          pre_data;
        int          body_bytes;
        int          keep;
        int          i;
        pre_fmt  = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : 0;
        pre_data = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : 0;
        fmt_code = FORMAT_PCM;
        data_len = $urandom_range(12);
        if (flavor == FL_NOT_PCM) begin
            fmt_code = 16'($urandom);
            if (fmt_code == FORMAT_PCM) fmt_code = 16'h0000;
        end
        if (flavor == FL_EMPTY) data_len = 32'd0;
        if (flavor == FL_HUGE) data_len = pick_field();
        body_bytes = (data_len > MAX_PAYLOAD) ? $urandom_range(MAX_PAYLOAD) : int'(data_len);

        file_image.delete();
        add_tag(TAG_RIFF);
        add_le(32'd0, 4);
        add_tag(TAG_WAVE);
        add_junk(pre_fmt);
        add_tag(TAG_FMT);
        add_le($urandom, 4);
        add_le(32'(fmt_code), 2);
        add_le(pick_field(), 2);
        add_le(pick_field(), 4);
        add_le(pick_field(), 4);
        add_le(pick_field(), 2);
        add_le(pick_field(), 2);
        add_junk(pre_data);
        add_tag(TAG_DATA);
        add_le(data_len, 4);
        add_junk(body_bytes);

        // The RIFF size decides how far the tag searches may run.
        case (flavor)
            FL_NO_FMT:  riff_field = $urandom_range(4 + pre_fmt);
            FL_NO_DATA: riff_field = $urandom_range(5 + pre_fmt, 28 + pre_fmt + pre_data);
            FL_HUGE:    riff_field = 32'hFFFF_FFFF;
            default:    riff_field = file_image.size() - 8 + $urandom_range(3);
        endcase
        for (i = 0; i < 4; i++) file_image[4 + i] = riff_field[8*i +: 8];

        case (flavor)
            FL_CORRUPT: file_image[$urandom_range(file_image.size() - 1)] = 8'($urandom);
            FL_CUT: begin
                keep = $urandom_range(1, file_image.size() - 1);
                while (file_image.size() > keep) void'(file_image.pop_back());
            end
            FL_TRAIL: add_junk($urandom_range(1, 6));
            FL_NOISE: begin
                file_image.delete();
                add_junk($urandom_range(1, 12));
            end
            default: ;
        endcase
    endtask

    // Sender: offers queued bytes and predicts each accepted beat.
    always @(posedge i_clk) begin : drive_bytes
        logic took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                parse_wav_byte(i_in_data);
                beats_accepted++;
            end
            if (!i_in_valid || took) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold that fills the block.
    always @(posedge i_clk) begin : pace_results
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (stall_armed && !stall_done) begin
                stall_left = LONG_HOLD;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (parse_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result of kind %0d", o_out_data.kind));
            end else begin
                want = parse_results_due.pop_front();
                check_field("kind", 32'(o_out_data.kind), 32'(want.kind));
                check_field("error_code", 32'(o_out_data.error_code), 32'(want.error_code));
                check_field("channels", 32'(o_out_data.channels), 32'(want.channels));
                check_field("sample_rate", o_out_data.sample_rate, want.sample_rate);
                check_field("avg_byte_rate", o_out_data.avg_byte_rate, want.avg_byte_rate);
                check_field("block_align", 32'(o_out_data.block_align), 32'(want.block_align));
                check_field("sample_bits", 32'(o_out_data.sample_bits), 32'(want.sample_bits));
                check_field("data_size", o_out_data.data_size, want.data_size);
                check_field("payload_byte", 32'(o_out_data.payload_byte),
                            32'(want.payload_byte));
                check_field("last", 32'(o_out_data.last), 32'(want.last));
            end
            if (o_out_data.kind <= KIND_PAYLOAD) kind_seen[o_out_data.kind]++;
            results_seen++;
        end
    end

    initial begin : stimulus
        int      stage;
        int      stage_end;
        t_flavor flavor;
        int      r;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (stage = 0; stage < 3; stage++) begin
            @(negedge i_clk);
            // Sender idles lightly while the receiver idles heavily, then the
            // reverse, then both run flat out behind one long output hold.
            send_idle_pct = (stage == 0) ? 15 : (stage == 1) ? 61 : 0;
            recv_idle_pct = (stage == 0) ? 61 : (stage == 1) ? 15 : 0;
            if (stage == 2) stall_armed = 1'b1;
            if (stage == 0) begin
                // Bytes before any file start are dropped.
                file_image.delete();
                add_le(32'h0000_FF00, 2);
                queue_image(1'b0);
                // Bad RIFF tag, then a stray byte after the error.
                file_image.delete();
                add_tag(NOT_RIFF_TAG);
                add_le(32'h0000_00FF, 1);
                queue_image(1'b1);
                // Largest RIFF size with a bad WAVE tag.
                file_image.delete();
                add_tag(TAG_RIFF);
                add_le(32'hFFFF_FFFF, 4);
                add_tag(NOT_WAVE_TAG);
                queue_image(1'b1);
                // A file abandoned after two bytes by the next start.
                file_image.delete();
                add_le(32'h0000_4952, 2);
                queue_image(1'b1);
            end
            stage_end = beats_queued + PHASE_BEATS;
            while (beats_queued < stage_end) begin
                if (files_queued < int'(FL_COUNT)) begin
                    flavor = t_flavor'(files_queued % int'(FL_COUNT));
                end else begin
                    r = $urandom_range(94);
                    flavor = (r < 50) ? FL_CLEAN : t_flavor'(1 + (r - 50) / 5);
                end
                build_wav_file(flavor);
                queue_image(1'b1);
            end
            while (pending_bytes.size() != 0 || i_in_valid || parse_results_due.size() != 0)
                @(negedge i_clk);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Streamed %0d bytes in %0d files over three pacing phases and a %0d-cycle hold.",
                 beats_accepted, files_queued, LONG_HOLD);
        $display("Compared %0d headers, %0d errors and %0d payload bytes; %0d mismatches.",
                 kind_seen[0], kind_seen[1], kind_seen[2], mismatches);
        if (mismatches == 0 && parse_results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results outstanding.", parse_results_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: wav_header_parser.f
src/whp_pkg.sv
src/wav_header_parser.sv
tb/wav_header_parser_test.sv
